>>> rtl/sb2d_pkg.sv
package sb2d_pkg;

    // default width of the input integer
    localparam int SB2D_VALUE_BITS = 32;

    // ascii codes, cut to the 6-bit character field
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // commands from the sequencer to the bcd shift unit
    typedef struct packed {
        logic start;        // load a new magnitude and clear the bcd word
        logic shift_digit;  // drop the top digit, shift the rest up one place
    } sb2d_cmd_t;

    // decimal digits needed for an unsigned value of the given width
    // (floor(bits * log10(2)) + 1; 2**bits is never a power of ten)
    function automatic int sb2d_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

endpackage

>>> rtl/sb2d_dabble.sv
module sb2d_dabble
    import sb2d_pkg::*;
#(
    parameter int VALUE_BITS = SB2D_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sb2d_cmd_t             cmd,
    input  logic [VALUE_BITS-1:0] mag,
    output logic                  done,
    output logic [3:0]            top_digit
);

    localparam int DIGITS = sb2d_digits(VALUE_BITS);
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    // add-3 correction on every digit of five or more
    always_comb
    begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int i = 0; i < DIGITS; i++)
        begin
            dig = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    // while busy, one magnitude bit enters the bcd word per cycle, msb first
    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.start)
        begin
            mag_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
        else if (cmd.shift_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'b0000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign done      = busy_reg && (cnt_reg == CNT_W'(1));
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

>>> rtl/signed_binary_to_decimal_ascii.sv
// Converts one two's-complement integer of VALUE_BITS bits into its decimal
// text, sent as a stream of ASCII characters, most significant first: a '-'
// first for a negative value, no leading zeros, a single '0' for zero, and
// the most negative value converted exactly. The final character of each
// number carries last = 1. One number is in work at a time. After a value
// transfer the magnitude is shifted into a bcd register one bit per cycle,
// then leading zero digits are dropped one per cycle, then one character is
// offered per cycle while the output register is free or being taken. DIGITS,
// the decimal width of the magnitude, is 10 at 32 bits. The next value is
// taken as soon as the last character sits in the output register.
module signed_binary_to_decimal_ascii
    import sb2d_pkg::*;
#(
    parameter int VALUE_BITS = SB2D_VALUE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         value_valid,
    output logic                         value_ready,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         text_valid,
    input  logic                         text_ready,
    output logic [5:0]                   character,
    output logic                         last
);

    localparam int DIGITS = sb2d_digits(VALUE_BITS);
    localparam int DCNT_W = $clog2(DIGITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic                  neg_reg, neg_next;
    logic [DCNT_W-1:0]     left_reg, left_next;
    logic                  out_valid_reg, out_valid_next;
    logic [5:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] mag;
    logic                  in_xfer;
    logic                  out_free;
    logic                  conv_done;
    logic [3:0]            top_digit;
    sb2d_cmd_t             cmd;

    assign value_u  = value;
    assign in_xfer  = value_valid && value_ready;
    assign out_free = !out_valid_reg || text_ready;

    // magnitude of the input; the most negative value maps to 2**(VALUE_BITS-1)
    assign mag = value_u[VALUE_BITS-1]
               ? (~value_u + {{(VALUE_BITS-1){1'b0}}, 1'b1})
               : value_u;

    sb2d_dabble #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mag       (mag),
        .done      (conv_done),
        .top_digit (top_digit)
    );

    // sequencer and output register
    always_comb
    begin
        state_next      = state_reg;
        neg_next        = neg_reg;
        left_next       = left_reg;
        out_valid_next  = out_valid_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        cmd.start       = 1'b0;
        cmd.shift_digit = 1'b0;

        if (out_valid_reg && text_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd.start  = 1'b1;
                    neg_next   = value_u[VALUE_BITS-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    left_next  = DCNT_W'(DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros but keep at least one digit
                if (top_digit == 4'd0 && left_reg != DCNT_W'(1))
                begin
                    cmd.shift_digit = 1'b1;
                    left_next       = left_reg - DCNT_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    char_next       = CHAR_ZERO + {2'b00, top_digit};
                    last_next       = (left_reg == DCNT_W'(1));
                    cmd.shift_digit = 1'b1;
                    left_next       = left_reg - DCNT_W'(1);
                    if (left_reg == DCNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        left_reg <= left_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign value_ready = (state_reg == ST_IDLE);
    assign text_valid  = out_valid_reg;
    assign character   = char_reg;
    assign last        = last_reg;

endmodule
